FILE: sv/tfpid_pkg.sv
// shared types, constants and codes of the target-follow pid mode controller
package tfpid_pkg;

  // axis lanes and scan pattern
  localparam int NAX         = 3;
  localparam int AXES        = 3;
  localparam int SCAN_POINTS = 6;

  // field and datapath widths
  localparam int EW     = 24;  // input error
  localparam int XW     = 25;  // axis value with standoff
  localparam int PW     = 20;  // frame period
  localparam int GW     = 16;  // gains
  localparam int RW     = 12;  // lock radius
  localparam int CW     = 4;   // lock frames, retry limit
  localparam int VW     = 32;  // command vector
  localparam int SUM_W  = 52;  // pid sum in 1/256 units
  localparam int MA_W   = 29;  // multiplier operand a
  localparam int MB_W   = 27;  // multiplier operand b
  localparam int PR_W   = MA_W + MB_W;
  localparam int SQ_W   = 50;  // sum of squares
  localparam int DT_W   = 49;  // integer part of d term
  localparam int DVD_W  = 64;  // divider dividend
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = DVD_W / DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_CYC);

  localparam logic [PW-1:0]      DIV_I        = 20'd1000000;
  localparam logic [DVD_W-1:0]   Q_LIM        = 64'h0000_0000_1000_0000;
  localparam logic [SUM_W-2:0]   D_CLAMP      = 51'h1_0000_0000_0000;
  localparam logic [XW-1:0]      RELEASE_LIFT = 25'd80;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_PROP,
    CFG_GAIN_INTEGRAL,
    CFG_GAIN_DERIV,
    CFG_LOCK_RADIUS,
    CFG_LOCK_FRAMES,
    CFG_RETRY_LIMIT,
    CFG_Z_STANDOFF
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_SCAN,
    KIND_FOLLOW,
    KIND_NUDGE,
    KIND_PICK
  } cmd_kind_t;

  typedef enum logic [1:0] {
    MODE_SCAN,
    MODE_FOLLOW,
    MODE_TRY
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_R,
    ST_LOCK,
    ST_P_MUL,
    ST_P_ACC,
    ST_GIP,
    ST_I_LO,
    ST_I_HI,
    ST_I_DSTART,
    ST_I_DWAIT,
    ST_D_MUL,
    ST_D_DSTART,
    ST_D_DWAIT,
    ST_Q_MUL,
    ST_R_MUL,
    ST_R_DSTART,
    ST_R_DWAIT,
    ST_AX_END,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 in_view;
    logic signed [EW-1:0] err_x;
    logic signed [EW-1:0] err_y;
    logic signed [EW-1:0] err_z;
    logic [PW-1:0]        frame_period;
    logic                 arm_idle;
    logic                 grab_mode;
  } in_item_t;

  typedef struct packed {
    cmd_kind_t            cmd_kind;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
    logic [2:0]           waypoint;
    logic                 move_done;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [PW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [PW-1:0]    rem;
  } div_rsp_t;

endpackage

FILE: sv/target_follow_pid_mode_controller.sv
// top level: scan / follow / try-follow mode machine with a sequenced three-axis pid
// scan, nudge and idle items go straight from the accept to ST_OUT to be registered
// follow items: lock test, pid steps of each axis, then the result is registered
// pick/release ends at the lock test; per axis up to three divider passes dominate
// one item at a time: in_stall is high from accept until the result is registered
// synchronous active-low reset: mode scan, counters and pid history zero, gains at defaults
module target_follow_pid_mode_controller #(
  parameter int AXES        = tfpid_pkg::AXES,
  parameter int SCAN_POINTS = tfpid_pkg::SCAN_POINTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tfpid_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tfpid_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import tfpid_pkg::*;

  // configuration
  logic [GW-1:0] gain_prop_r, gain_integral_r, gain_deriv_r, z_standoff_r;
  logic [RW-1:0] lock_radius_r;
  logic [CW-1:0] lock_frames_r, retry_limit_r;

  // control
  state_t     state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  logic [3:0] lock_cnt_r, lock_cnt_nxt;
  logic [4:0] retry_r, retry_nxt;
  logic [2:0] scan_idx_r, scan_idx_nxt;
  logic       from_follow_r, from_follow_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       out_valid_r, out_valid_nxt;

  // pid history lanes
  logic signed [XW-1:0] hx1_r [NAX];
  logic signed [XW-1:0] hx1_nxt [NAX];
  logic signed [XW-1:0] hx2_r [NAX];
  logic signed [XW-1:0] hx2_nxt [NAX];
  logic signed [VW-1:0] hy_r [NAX];
  logic signed [VW-1:0] hy_nxt [NAX];

  // datapath
  logic signed [EW-1:0]  ex_r, ex_nxt, ey_r, ey_nxt, ez_r, ez_nxt;
  logic signed [XW-1:0]  v_r [NAX];
  logic signed [XW-1:0]  v_nxt [NAX];
  logic [PW-1:0]         per_r, per_nxt;
  logic                  grab_r, grab_nxt;
  logic [PR_W-1:0]       prod_r, prod_nxt;
  logic [MA_W-1:0]       mul_a;
  logic [MB_W-1:0]       mul_b;
  logic [SQ_W-1:0]       acc_r, acc_nxt;
  logic [17:0]           gip_hi_r, gip_hi_nxt;
  logic [DVD_W-1:0]      num_r, num_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [MA_W-1:0]       q_r, q_nxt;
  logic [PW-1:0]         r_r, r_nxt;
  logic [DT_W-1:0]       dt_r, dt_nxt;
  cmd_kind_t             res_kind_r, res_kind_nxt;
  logic signed [VW-1:0]  res_vec_r [NAX];
  logic signed [VW-1:0]  res_vec_nxt [NAX];
  logic [2:0]            res_wp_r, res_wp_nxt;
  logic                  res_done_r, res_done_nxt;
  out_item_t             out_item_r, out_item_nxt;

  // divider link
  div_req_t div_req;
  div_rsp_t div_rsp;

  // current axis operands
  logic signed [XW-1:0]  x_c, x1_c, x2_c;
  logic signed [VW-1:0]  y1_c;
  logic signed [XW:0]    d1_c;
  logic signed [XW+1:0]  d2_c;
  logic [XW-1:0]         x_mag;
  logic [XW:0]           d1_mag;
  logic [XW+1:0]         d2_mag;
  logic [XW-1:0]         vx_mag, vy_mag, vz_mag;

  function automatic logic signed [SUM_W-1:0] sadd(
    input logic signed [SUM_W-1:0] s,
    input logic [SUM_W-2:0]        m,
    input logic                    neg
  );
    logic signed [SUM_W-1:0] e;
    e = $signed({1'b0, m});
    return neg ? s - e : s + e;
  endfunction

  function automatic logic [XW-1:0] mag25(input logic signed [XW-1:0] v);
    return v[XW-1] ? XW'(~v + 1'b1) : XW'(v);
  endfunction

  tfpid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign x_c    = v_r[ax_r];
  assign x1_c   = hx1_r[ax_r];
  assign x2_c   = hx2_r[ax_r];
  assign y1_c   = hy_r[ax_r];
  assign d1_c   = {x_c[XW-1], x_c} - {x1_c[XW-1], x1_c};
  assign d2_c   = {{2{x_c[XW-1]}}, x_c} - {x1_c[XW-1], x1_c, 1'b0}
                  + {{2{x2_c[XW-1]}}, x2_c};
  assign x_mag  = mag25(x_c);
  assign d1_mag = d1_c[XW] ? (XW+1)'(~d1_c + 1'b1) : (XW+1)'(d1_c);
  assign d2_mag = d2_c[XW+1] ? (XW+2)'(~d2_c + 1'b1) : (XW+2)'(d2_c);
  assign vx_mag = mag25(v_r[0]);
  assign vy_mag = mag25(v_r[1]);
  assign vz_mag = mag25(v_r[2]);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ_X: begin
        mul_a = MA_W'(vx_mag);
        mul_b = MB_W'(vx_mag);
      end
      ST_SQ_Y: begin
        mul_a = MA_W'(vy_mag);
        mul_b = MB_W'(vy_mag);
      end
      ST_SQ_Z: begin
        mul_a = MA_W'(vz_mag);
        mul_b = MB_W'(vz_mag);
      end
      ST_SQ_R: begin
        mul_a = MA_W'(lock_radius_r);
        mul_b = MB_W'(lock_radius_r);
      end
      ST_P_MUL: begin
        mul_a = MA_W'(d1_mag);
        mul_b = MB_W'(gain_prop_r);
      end
      ST_P_ACC: begin
        mul_a = MA_W'(per_r);
        mul_b = MB_W'(gain_integral_r);
      end
      ST_GIP: begin
        mul_a = MA_W'(x_mag);
        mul_b = MB_W'(prod_r[17:0]);
      end
      ST_I_LO: begin
        mul_a = MA_W'(x_mag);
        mul_b = MB_W'(gip_hi_r);
      end
      ST_D_MUL: begin
        mul_a = MA_W'(d2_mag);
        mul_b = MB_W'(gain_deriv_r);
      end
      ST_Q_MUL: begin
        mul_a = q_r;
        mul_b = MB_W'(DIV_I);
      end
      ST_R_MUL: begin
        mul_a = MA_W'(r_r);
        mul_b = MB_W'(DIV_I);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PR_W'(mul_a) * PR_W'(mul_b);

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(prod_r);
    div_req.divisor  = per_r;
    case (state_r)
      ST_I_DSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_r;
        div_req.divisor  = DIV_I;
      end
      ST_D_DSTART, ST_R_DSTART: begin
        div_req.start = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // sequencer: mode machine, lock test and pid steps
  always_comb begin
    logic [3:0]              need;
    logic [3:0]              lc_inc;
    logic                    in_lock;
    logic signed [SUM_W-1:0] rnd;
    logic signed [SUM_W-9:0] sh;
    logic signed [VW-1:0]    y;
    logic signed [XW-1:0]    ez_l;
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    lock_cnt_nxt    = lock_cnt_r;
    retry_nxt       = retry_r;
    scan_idx_nxt    = scan_idx_r;
    from_follow_nxt = from_follow_r;
    ax_nxt          = ax_r;
    out_valid_nxt   = out_valid_r;
    hx1_nxt         = hx1_r;
    hx2_nxt         = hx2_r;
    hy_nxt          = hy_r;
    ex_nxt          = ex_r;
    ey_nxt          = ey_r;
    ez_nxt          = ez_r;
    v_nxt           = v_r;
    per_nxt         = per_r;
    grab_nxt        = grab_r;
    acc_nxt         = acc_r;
    gip_hi_nxt      = gip_hi_r;
    num_nxt         = num_r;
    sum_nxt         = sum_r;
    q_nxt           = q_r;
    r_nxt           = r_r;
    dt_nxt          = dt_r;
    res_kind_nxt    = res_kind_r;
    res_vec_nxt     = res_vec_r;
    res_wp_nxt      = res_wp_r;
    res_done_nxt    = res_done_r;
    out_item_nxt    = out_item_r;
    need    = (lock_frames_r == '0) ? 4'd1 : lock_frames_r;
    lc_inc  = (lock_cnt_r == 4'd15) ? 4'd15 : lock_cnt_r + 4'd1;
    in_lock = acc_r < SQ_W'(prod_r[2*RW-1:0]);
    rnd     = sum_r + SUM_W'(128);
    sh      = rnd[SUM_W-1:8];
    if ((&sh[SUM_W-9:VW-1]) || !(|sh[SUM_W-9:VW-1])) begin
      y = sh[VW-1:0];
    end else begin
      y = sh[SUM_W-9] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    ez_l = {ez_r[EW-1], ez_r} + (grab_r ? '0 : RELEASE_LIFT);

    // output register drains independently
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ex_nxt   = in_item.err_x;
          ey_nxt   = in_item.err_y;
          ez_nxt   = in_item.err_z;
          v_nxt[0] = {in_item.err_x[EW-1], in_item.err_x};
          v_nxt[1] = {in_item.err_y[EW-1], in_item.err_y};
          v_nxt[2] = {in_item.err_z[EW-1], in_item.err_z}
                     + {{(XW-GW){1'b0}}, z_standoff_r};
          per_nxt  = (in_item.frame_period == '0) ? PW'(1) : in_item.frame_period;
          grab_nxt = in_item.grab_mode;
          res_kind_nxt = KIND_NONE;
          for (int i = 0; i < NAX; i++) begin
            res_vec_nxt[i] = '0;
          end
          res_wp_nxt      = '0;
          res_done_nxt    = 1'b0;
          from_follow_nxt = 1'b0;
          state_nxt       = ST_OUT;
          case (mode_r)
            MODE_FOLLOW: begin
              if (!in_item.in_view) begin
                mode_nxt       = MODE_TRY;
                res_kind_nxt   = KIND_NUDGE;
                res_vec_nxt[0] = {{(VW-XW+1){hx1_r[0][XW-1]}}, hx1_r[0][XW-1:1]};
                res_vec_nxt[1] = (AXES > 1)
                                 ? {{(VW-XW+1){hx1_r[1][XW-1]}}, hx1_r[1][XW-1:1]} : '0;
                retry_nxt      = (retry_r == 5'd31) ? 5'd31 : retry_r + 5'd1;
              end else begin
                from_follow_nxt = 1'b1;
                state_nxt       = ST_SQ_X;
              end
            end
            MODE_TRY: begin
              if (in_item.in_view) begin
                mode_nxt  = MODE_FOLLOW;
                retry_nxt = '0;
                state_nxt = ST_SQ_X;
              end else if (retry_r > {1'b0, retry_limit_r}) begin
                mode_nxt  = MODE_SCAN;
                retry_nxt = '0;
                if (in_item.arm_idle) begin
                  res_kind_nxt = KIND_SCAN;
                  res_wp_nxt   = scan_idx_r;
                  scan_idx_nxt = (scan_idx_r == 3'(SCAN_POINTS - 1)) ? '0
                                 : scan_idx_r + 3'd1;
                end
              end else begin
                res_kind_nxt   = KIND_NUDGE;
                res_vec_nxt[0] = {{(VW-XW+1){hx1_r[0][XW-1]}}, hx1_r[0][XW-1:1]};
                res_vec_nxt[1] = (AXES > 1)
                                 ? {{(VW-XW+1){hx1_r[1][XW-1]}}, hx1_r[1][XW-1:1]} : '0;
                retry_nxt      = (retry_r == 5'd31) ? 5'd31 : retry_r + 5'd1;
              end
            end
            default: begin
              if (in_item.in_view) begin
                mode_nxt     = MODE_FOLLOW;
                scan_idx_nxt = '0;
                state_nxt    = ST_SQ_X;
              end else begin
                mode_nxt = MODE_SCAN;
                if (in_item.arm_idle) begin
                  res_kind_nxt = KIND_SCAN;
                  res_wp_nxt   = scan_idx_r;
                  scan_idx_nxt = (scan_idx_r == 3'(SCAN_POINTS - 1)) ? '0
                                 : scan_idx_r + 3'd1;
                end
              end
            end
          endcase
        end
      end
      // squared distance against squared radius
      ST_SQ_X: state_nxt = ST_SQ_Y;
      ST_SQ_Y: begin
        acc_nxt   = prod_r[SQ_W-1:0];
        state_nxt = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        acc_nxt   = acc_r + prod_r[SQ_W-1:0];
        state_nxt = ST_SQ_R;
      end
      ST_SQ_R: begin
        acc_nxt   = acc_r + prod_r[SQ_W-1:0];
        state_nxt = ST_LOCK;
      end
      ST_LOCK: begin
        if (in_lock && (lc_inc >= need)) begin
          lock_cnt_nxt   = '0;
          res_kind_nxt   = KIND_PICK;
          res_vec_nxt[0] = {{(VW-EW){ex_r[EW-1]}}, ex_r};
          res_vec_nxt[1] = {{(VW-EW){ey_r[EW-1]}}, ey_r};
          res_vec_nxt[2] = {{(VW-XW){ez_l[XW-1]}}, ez_l};
          if (from_follow_r) begin
            res_done_nxt = 1'b1;
            mode_nxt     = MODE_SCAN;
            for (int i = 0; i < NAX; i++) begin
              hx1_nxt[i] = '0;
              hx2_nxt[i] = '0;
              hy_nxt[i]  = '0;
            end
          end
          state_nxt = ST_OUT;
        end else begin
          lock_cnt_nxt = in_lock ? lc_inc : 4'd0;
          res_kind_nxt = KIND_FOLLOW;
          ax_nxt       = '0;
          state_nxt    = ST_P_MUL;
        end
      end
      // proportional term and previous output
      ST_P_MUL: state_nxt = ST_P_ACC;
      ST_P_ACC: begin
        sum_nxt   = sadd({{(SUM_W-VW-8){y1_c[VW-1]}}, y1_c, 8'd0},
                         prod_r[SUM_W-2:0], d1_c[XW]);
        state_nxt = ST_GIP;
      end
      // integral term: gain * period * x / 1e6
      ST_GIP: begin
        gip_hi_nxt = prod_r[35:18];
        state_nxt  = ST_I_LO;
      end
      ST_I_LO: begin
        num_nxt   = DVD_W'(prod_r);
        state_nxt = ST_I_HI;
      end
      ST_I_HI: begin
        num_nxt   = num_r + (DVD_W'(prod_r) << 18);
        state_nxt = ST_I_DSTART;
      end
      ST_I_DSTART: state_nxt = ST_I_DWAIT;
      ST_I_DWAIT: begin
        if (div_rsp.done) begin
          sum_nxt   = sadd(sum_r, div_rsp.quot[SUM_W-2:0], x_c[XW-1]);
          state_nxt = ST_D_MUL;
        end
      end
      // derivative term: gain * second difference * 1e6 / period
      ST_D_MUL:    state_nxt = ST_D_DSTART;
      ST_D_DSTART: state_nxt = ST_D_DWAIT;
      ST_D_DWAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > Q_LIM) begin
            sum_nxt   = sadd(sum_r, D_CLAMP, d2_c[XW+1]);
            state_nxt = ST_AX_END;
          end else begin
            q_nxt     = div_rsp.quot[MA_W-1:0];
            r_nxt     = div_rsp.rem;
            state_nxt = ST_Q_MUL;
          end
        end
      end
      ST_Q_MUL: state_nxt = ST_R_MUL;
      ST_R_MUL: begin
        dt_nxt    = prod_r[DT_W-1:0];
        state_nxt = ST_R_DSTART;
      end
      ST_R_DSTART: state_nxt = ST_R_DWAIT;
      ST_R_DWAIT: begin
        if (div_rsp.done) begin
          sum_nxt   = sadd(sum_r, (SUM_W-1)'(dt_r) + (SUM_W-1)'(div_rsp.quot[PW-1:0]),
                           d2_c[XW+1]);
          state_nxt = ST_AX_END;
        end
      end
      // round, saturate and shift the axis history
      ST_AX_END: begin
        res_vec_nxt[ax_r] = y;
        hy_nxt[ax_r]      = y;
        hx2_nxt[ax_r]     = x1_c;
        hx1_nxt[ax_r]     = x_c;
        if (ax_r == 2'(AXES - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_P_MUL;
        end
      end
      // hand the result to the output register
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_item_nxt.cmd_kind  = res_kind_r;
          out_item_nxt.vec_x     = res_vec_r[0];
          out_item_nxt.vec_y     = res_vec_r[1];
          out_item_nxt.vec_z     = res_vec_r[2];
          out_item_nxt.waypoint  = res_wp_r;
          out_item_nxt.move_done = res_done_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state, history and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      mode_r          <= MODE_SCAN;
      lock_cnt_r      <= '0;
      retry_r         <= '0;
      scan_idx_r      <= '0;
      from_follow_r   <= 1'b0;
      ax_r            <= '0;
      out_valid_r     <= 1'b0;
      gain_prop_r     <= 16'd51;
      gain_integral_r <= 16'd26;
      gain_deriv_r    <= 16'd0;
      lock_radius_r   <= 12'd48;
      lock_frames_r   <= 4'd5;
      retry_limit_r   <= 4'd5;
      z_standoff_r    <= 16'd1920;
      for (int i = 0; i < NAX; i++) begin
        hx1_r[i] <= '0;
        hx2_r[i] <= '0;
        hy_r[i]  <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      lock_cnt_r    <= lock_cnt_nxt;
      retry_r       <= retry_nxt;
      scan_idx_r    <= scan_idx_nxt;
      from_follow_r <= from_follow_nxt;
      ax_r          <= ax_nxt;
      out_valid_r   <= out_valid_nxt;
      hx1_r         <= hx1_nxt;
      hx2_r         <= hx2_nxt;
      hy_r          <= hy_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_GAIN_PROP:     gain_prop_r     <= cfg_data;
          CFG_GAIN_INTEGRAL: gain_integral_r <= cfg_data;
          CFG_GAIN_DERIV:    gain_deriv_r    <= cfg_data;
          CFG_LOCK_RADIUS:   lock_radius_r   <= cfg_data[RW-1:0];
          CFG_LOCK_FRAMES:   lock_frames_r   <= cfg_data[CW-1:0];
          CFG_RETRY_LIMIT:   retry_limit_r   <= cfg_data[CW-1:0];
          CFG_Z_STANDOFF:    z_standoff_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    ez_r       <= ez_nxt;
    v_r        <= v_nxt;
    per_r      <= per_nxt;
    grab_r     <= grab_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    gip_hi_r   <= gip_hi_nxt;
    num_r      <= num_nxt;
    sum_r      <= sum_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    dt_r       <= dt_nxt;
    res_kind_r <= res_kind_nxt;
    res_vec_r  <= res_vec_nxt;
    res_wp_r   <= res_wp_nxt;
    res_done_r <= res_done_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
  a_div_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_rsp.done)
    else $error("divider finished one cycle after start");

  a_done_only_on_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.move_done) |-> (out_item_r.cmd_kind == KIND_PICK))
    else $error("move_done on an item that is not a pick");

  a_scan_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r <= 3'(SCAN_POINTS - 1))
    else $error("scan index beyond the waypoint list");

  a_idle_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.cmd_kind == KIND_NONE || out_item_r.cmd_kind == KIND_SCAN))
    |-> (out_item_r.vec_x == '0 && out_item_r.vec_y == '0 && out_item_r.vec_z == '0))
    else $error("nonzero vector on an idle or scan item");

  a_wait_states_need_div: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_I_DSTART) |-> (state_r == ST_I_DWAIT))
    else $error("integral divide not awaited");
`endif

endmodule

FILE: sv/tfpid_div.sv
// shared unsigned divider, four restoring steps per cycle
module tfpid_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tfpid_pkg::div_req_t req,
  output tfpid_pkg::div_rsp_t rsp
);
  import tfpid_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [PW-1:0]     rem_r, rem_nxt;
  logic [PW-1:0]     dvs_r, dvs_nxt;

  // one cycle of the shift-subtract iteration
  always_comb begin
    logic [PW:0]      t;
    logic [PW-1:0]    r;
    logic [DVD_W-1:0] q;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    r = rem_r;
    q = quo_r;
    t = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {r, q[DVD_W-1]};
      q = {q[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
        q[0] = 1'b1;
      end
      r = t[PW-1:0];
    end
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = q;
      rem_nxt = r;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: tb/sv/tb.sv
// testbench of the target-follow pid mode controller: directed table, then random phases
`timescale 1ns / 100ps

module tb;
  import tfpid_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  target_follow_pid_mode_controller DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock, period 8 ns
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // mirror of the controller state and registers
  int unsigned gain_p, gain_i, gain_d, radius, frames_need, retries_max, standoff;
  mode_t       ctl_mode;
  int unsigned lock_cnt, retry_cnt, scan_idx;
  longint      hist_x1[3], hist_x2[3], hist_y[3];

  out_item_t   cmd_queue[$];
  int          n_items, n_checked, n_picks, n_errors;
  int          send_idle_pct, recv_stall_pct, hold_left;

  // directed table row
  typedef struct {
    in_item_t  frame;
    bit        typed;
    out_item_t cmd;
  } frame_row_t;
  frame_row_t rows[$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void clear_hist();
    for (int a = 0; a < 3; a++) begin
      hist_x1[a] = 0; hist_x2[a] = 0; hist_y[a] = 0;
    end
  endfunction

  function automatic void reset_model();
    gain_p = 51; gain_i = 26; gain_d = 0; radius = 48;
    frames_need = 5; retries_max = 5; standoff = 1920;
    ctl_mode = MODE_SCAN; lock_cnt = 0; retry_cnt = 0; scan_idx = 0;
    clear_hist();
  endfunction

  // velocity-form pid step of one axis
  function automatic longint pid_step(int a, longint x, longint per);
    longint x1 = hist_x1[a];
    longint x2 = hist_x2[a];
    longint p, it, dd, q, r, dt, s, y;
    p  = longint'(gain_p) * (x - x1);
    it = (longint'(gain_i) * per * x) / 1000000;
    dd = longint'(gain_d) * (x - 2 * x1 + x2);
    q  = dd / per;
    r  = dd % per;
    if (q > (longint'(1) <<< 28)) dt = longint'(1) <<< 48;
    else if (q < -(longint'(1) <<< 28)) dt = -(longint'(1) <<< 48);
    else dt = q * 1000000 + (r * 1000000) / per;
    s = hist_y[a] * 256 + p + it + dt;
    y = sat32((s + 128) >>> 8);
    hist_y[a] = y;
    hist_x2[a] = x1;
    hist_x1[a] = x;
    return y;
  endfunction

  // lock test, then pick/release or pid velocity
  function automatic bit follow_step(longint e[3], longint per, bit grab,
                                     output out_item_t o);
    longint v[3];
    longint c[3];
    longint rr;
    int unsigned need;
    o = '0;
    rr = longint'(radius) * longint'(radius);
    need = (frames_need != 0) ? frames_need : 1;
    v[0] = e[0]; v[1] = e[1]; v[2] = e[2] + longint'(standoff);
    if (v[0] * v[0] + v[1] * v[1] + v[2] * v[2] < rr) begin
      if (lock_cnt < 15) lock_cnt++;
      if (lock_cnt >= need) begin
        lock_cnt = 0;
        o.cmd_kind = KIND_PICK;
        o.vec_x = e[0][31:0];
        o.vec_y = e[1][31:0];
        c[2] = e[2] + (grab ? 0 : 80);
        o.vec_z = c[2][31:0];
        return 1'b1;
      end
    end else begin
      lock_cnt = 0;
    end
    for (int a = 0; a < 3; a++) c[a] = (a < AXES) ? pid_step(a, v[a], per) : 0;
    o.cmd_kind = KIND_FOLLOW;
    o.vec_x = c[0][31:0];
    o.vec_y = c[1][31:0];
    o.vec_z = c[2][31:0];
    return 1'b0;
  endfunction

  function automatic out_item_t scan_step(bit idle);
    out_item_t o;
    int unsigned wp;
    o = '0;
    if (idle) begin
      wp = scan_idx % SCAN_POINTS;
      o.cmd_kind = KIND_SCAN;
      o.waypoint = wp[2:0];
      scan_idx = (wp + 1) % SCAN_POINTS;
    end else begin
      o.cmd_kind = KIND_NONE;
    end
    return o;
  endfunction

  function automatic out_item_t nudge_step();
    out_item_t o;
    longint nx, ny;
    o = '0;
    nx = hist_x1[0] >>> 1;
    ny = hist_x1[1] >>> 1;
    o.cmd_kind = KIND_NUDGE;
    o.vec_x = nx[31:0];
    o.vec_y = ny[31:0];
    if (retry_cnt < 31) retry_cnt++;
    return o;
  endfunction

  // expected command for one accepted frame
  function automatic out_item_t predict_cmd(in_item_t f);
    out_item_t o;
    longint e[3];
    longint per;
    bit picked;
    e[0] = longint'(f.err_x);
    e[1] = longint'(f.err_y);
    e[2] = longint'(f.err_z);
    per = longint'(f.frame_period);
    if (per == 0) per = 1;
    if (ctl_mode == MODE_FOLLOW) begin
      if (!f.in_view) begin
        ctl_mode = MODE_TRY;
        o = nudge_step();
      end else begin
        picked = follow_step(e, per, f.grab_mode, o);
        if (picked) begin
          clear_hist();
          ctl_mode = MODE_SCAN;
          o.move_done = 1'b1;
        end
      end
    end else if (ctl_mode == MODE_TRY) begin
      if (f.in_view) begin
        ctl_mode = MODE_FOLLOW;
        picked = follow_step(e, per, f.grab_mode, o);
        retry_cnt = 0;
      end else if (retry_cnt > retries_max) begin
        ctl_mode = MODE_SCAN;
        o = scan_step(f.arm_idle);
        retry_cnt = 0;
      end else begin
        o = nudge_step();
      end
    end else begin
      if (f.in_view) begin
        ctl_mode = MODE_FOLLOW;
        picked = follow_step(e, per, f.grab_mode, o);
        scan_idx = 0;
      end else begin
        ctl_mode = MODE_SCAN;
        o = scan_step(f.arm_idle);
      end
    end
    return o;
  endfunction

  function automatic in_item_t mk_frame(bit view, int x, int y, int z, int per,
                                        bit idle, bit grab);
    in_item_t f;
    f.in_view = view;
    f.err_x = x[23:0];
    f.err_y = y[23:0];
    f.err_z = z[23:0];
    f.frame_period = per[19:0];
    f.arm_idle = idle;
    f.grab_mode = grab;
    return f;
  endfunction

  function automatic void add_row(in_item_t f, bit typed, out_item_t c);
    frame_row_t r;
    r.frame = f; r.typed = typed; r.cmd = c;
    rows = {rows, r};
  endfunction

  // random frame: 45 percent near the target so lock and pick are reached
  function automatic in_item_t rand_frame();
    in_item_t f;
    int unsigned sel;
    int span;
    f = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(99);
    span = int'(radius) / 2 + 2;
    if (sel < 45) begin
      f.in_view = 1'b1;
      f.err_x = 24'($signed($urandom_range(2 * span)) - span);
      f.err_y = 24'($signed($urandom_range(2 * span)) - span);
      f.err_z = 24'(-int'(standoff) + $signed($urandom_range(2 * span)) - span);
      f.frame_period = 20'($urandom_range(100000, 50000));
    end else if (sel < 65) begin
      f.in_view = 1'b1;
    end else if (sel < 90) begin
      f.in_view = 1'b0;
    end
    return f;
  endfunction

  // drive one frame at the falling edge and wait for its accept
  task automatic send_frame(in_item_t f, bit typed, out_item_t c);
    out_item_t exp_cmd;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = f;
    do @(posedge clk); while (in_stall);
    exp_cmd = predict_cmd(f);
    if (typed) exp_cmd = c;
    cmd_queue = {cmd_queue, exp_cmd};
    if (exp_cmd.cmd_kind == KIND_PICK) n_picks++;
    n_items++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [15:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GAIN_PROP:     gain_p = d;
      CFG_GAIN_INTEGRAL: gain_i = d;
      CFG_GAIN_DERIV:    gain_d = d;
      CFG_LOCK_RADIUS:   radius = d[11:0];
      CFG_LOCK_FRAMES:   frames_need = d[3:0];
      CFG_RETRY_LIMIT:   retries_max = d[3:0];
      CFG_Z_STANDOFF:    standoff = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (cmd_queue.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // receiver stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_queue.size() == 0) begin
        $display("%0t: unexpected command %p", $time, out_item);
        n_errors++;
      end else begin
        e = cmd_queue.pop_front();
        n_checked++;
        if (out_item.cmd_kind !== e.cmd_kind || out_item.vec_x !== e.vec_x ||
            out_item.vec_y !== e.vec_y || out_item.vec_z !== e.vec_z ||
            out_item.waypoint !== e.waypoint || out_item.move_done !== e.move_done) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
          n_errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #20000000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    out_item_t c;
    logic [15:0] cfg_set[4][7];
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GAIN_PROP;
    cfg_data = '0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_items = 0; n_checked = 0; n_picks = 0; n_errors = 0;
    reset_model();
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table: scan after reset, extremes, zero period, nudges, lock and pick
    c = '0; c.cmd_kind = KIND_SCAN;
    add_row(mk_frame(0, 0, 0, 0, 1, 1, 0), 1, c);
    c = '0; c.cmd_kind = KIND_NONE;
    add_row(mk_frame(0, 5, 5, 5, 9, 0, 1), 1, c);
    c = '0; c.cmd_kind = KIND_SCAN; c.waypoint = 3'd1;
    add_row(mk_frame(0, -1, -1, -1, 9, 1, 0), 1, c);
    add_row(mk_frame(1, 8388607, 8388607, 8388607, 1048575, 1, 1), 0, c);
    add_row(mk_frame(1, -8388608, -8388608, -8388608, 0, 0, 0), 0, c);
    add_row(mk_frame(1, 8388607, -8388608, 0, 1, 1, 1), 0, c);
    add_row(mk_frame(0, 0, 0, 0, 1, 0, 0), 0, c);
    add_row(mk_frame(0, 0, 0, 0, 1, 1, 1), 0, c);
    add_row(mk_frame(1, -3, 7, 100, 77000, 0, 1), 0, c);
    for (int k = 0; k < 4; k++) add_row(mk_frame(1, 0, 0, -1920, 70000, 1, 1), 0, c);
    c = '0; c.cmd_kind = KIND_PICK; c.vec_z = -32'sd1920; c.move_done = 1'b1;
    add_row(mk_frame(1, 0, 0, -1920, 70000, 1, 1), 1, c);
    for (int k = 0; k < 9; k++) add_row(mk_frame(0, 3, 3, 3, 5, k[0], 0), 0, c);
    foreach (rows[i]) send_frame(rows[i].frame, rows[i].typed, rows[i].cmd);
    drain();

    // register sets: defaults-like, all high, all low, mixed
    cfg_set[0] = '{16'd51, 16'd26, 16'd300, 16'd400, 16'd3, 16'd2, 16'd1920};
    cfg_set[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFF, 16'hF, 16'hF, 16'hFFFF};
    cfg_set[2] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    cfg_set[3] = '{16'($urandom), 16'($urandom), 16'($urandom_range(2000)),
                   16'($urandom_range(4095, 300)), 16'($urandom_range(15, 1)),
                   16'($urandom_range(15)), 16'($urandom)};

    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 7; r++) cfg_write(cfg_idx_t'(r), cfg_set[ph][r]);
      for (int k = 0; k < 250; k++) begin
        if (ph == 0 && k == 100) hold_left = 3000;
        // stretches with no idling inside each phase
        if (k % 50 >= 40) begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end else begin
          case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
          endcase
        end
        send_frame(rand_frame(), 1'b0, c);
      end
      drain();
    end

    $display("tb: %0d frames sent, %0d commands checked, %0d picks/releases",
             n_items, n_checked, n_picks);
    $display("tb: four register sets incl. all-high and all-low, idle and stall phases");
    if (n_errors == 0 && cmd_queue.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
